FILE: hw/rtl/modular_inverse_macros.svh
// Assertion macros shared by the modular inverse RTL.
`ifndef MODULAR_INVERSE_MACROS_SVH
`define MODULAR_INVERSE_MACROS_SVH

// same-cycle implication
`define MI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("modular_inverse: assertion failed");

// next-cycle implication
`define MI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("modular_inverse: assertion failed");

`endif

FILE: hw/rtl/mi_pkg.sv
// ----------------------------------------------------------------------------
// mi_pkg
// Types, constants and helpers for the shift-and-add modular inverse.
// ----------------------------------------------------------------------------
package mi_pkg;

	localparam int unsigned WIDTH      = 32;
	localparam int unsigned DW         = 64;
	localparam int unsigned CW         = 8;
	localparam int unsigned ITER_LIMIT = 4 * WIDTH + 8;
	localparam int unsigned NCELLS     = 2;
	localparam int unsigned NW         = $clog2(WIDTH + 1);
	localparam int unsigned DCW        = $clog2(WIDTH);

	typedef struct packed {
		logic          live;
		logic          fin;
		logic          ok;
		logic [DW-1:0] u;
		logic [DW-1:0] v;
		logic [DW-1:0] r;
		logic [DW-1:0] s;
		logic [CW-1:0] cu;
		logic [CW-1:0] cv;
		logic [CW-1:0] steps;
	} mi_state_t;

	typedef struct packed {
		logic [DW-1:0] hi;
		logic [DW-1:0] nb;
		logic [DW-1:0] nb1;
		logic [DW-1:0] lo;
	} mi_masks_t;

	// x is +2^c or -2^c
	function automatic logic is_unit(input logic [DW-1:0] x, input logic [CW-1:0] c);
		logic [DW-1:0] pw;
		begin
			pw = {{(DW-1){1'b0}}, 1'b1} << c;
			return (c < CW'(DW - 1)) && ((x == pw) || (x == ({DW{1'b0}} - pw)));
		end
	endfunction

endpackage

FILE: hw/rtl/mi_cell.sv
// ----------------------------------------------------------------------------
// mi_cell
// One iteration step of the inverse loop; the state token hops cell to cell.
// ----------------------------------------------------------------------------
module mi_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  mi_pkg::mi_masks_t masks,
	input  mi_pkg::mi_state_t d,
	output mi_pkg::mi_state_t q
);

	mi_pkg::mi_state_t nx;
	mi_pkg::mi_state_t st_q;
	logic              u_free;
	logic              v_free;

	always_comb begin
		nx     = d;
		u_free = ((d.u & masks.hi) == '0) ||
			(((d.u & masks.nb) != '0) && ((d.u & masks.nb1) != '0) && ((d.u & masks.lo) != '0));
		v_free = ((d.v & masks.hi) == '0) ||
			(((d.v & masks.nb) != '0) && ((d.v & masks.nb1) != '0) && ((d.v & masks.lo) != '0));
		if (d.live && !d.fin) begin
			if (mi_pkg::is_unit(d.u, d.cu) || mi_pkg::is_unit(d.v, d.cv)) begin
				nx.fin = 1'b1;
				nx.ok  = 1'b1;
			end else if (d.steps >= mi_pkg::CW'(mi_pkg::ITER_LIMIT)) begin
				nx.fin = 1'b1;
				nx.ok  = 1'b0;
			end else begin
				nx.steps = d.steps + 1'b1;
				if (u_free) begin
					nx.u = d.u << 1;
					if (d.cu >= d.cv) nx.r = d.r << 1;
					else nx.s = {d.s[mi_pkg::DW-1], d.s[mi_pkg::DW-1:1]};
					nx.cu = d.cu + 1'b1;
				end else if (v_free) begin
					nx.v = d.v << 1;
					if (d.cv >= d.cu) nx.s = d.s << 1;
					else nx.r = {d.r[mi_pkg::DW-1], d.r[mi_pkg::DW-1:1]};
					nx.cv = d.cv + 1'b1;
				end else if (((d.v & masks.nb) != '0) == ((d.u & masks.nb) != '0)) begin
					if (d.cu <= d.cv) begin
						nx.u = d.u - d.v;
						nx.r = d.r - d.s;
					end else begin
						nx.v = d.v - d.u;
						nx.s = d.s - d.r;
					end
				end else begin
					if (d.cu <= d.cv) begin
						nx.u = d.u + d.v;
						nx.r = d.r + d.s;
					end else begin
						nx.v = d.v + d.u;
						nx.s = d.s + d.r;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= '0;
		else st_q <= nx;
	end

	assign q = st_q;

endmodule

FILE: hw/rtl/modular_inverse.sv
// ----------------------------------------------------------------------------
// modular_inverse
// Inverse of a value modulo an odd modulus, shift-and-add classical method.
// ----------------------------------------------------------------------------
// Input beat: value, modulus on in_valid / in_stall. Output beat: inverse,
// status on out_valid / out_stall. status 1 means no inverse exists (even or
// too small modulus, value not coprime, or step bound hit); inverse is then 0.
// One item is in flight at a time; in_stall is high from acceptance until
// the result is loaded into the output register.
// Flow: a bad modulus goes straight to the output stage; otherwise a
// restoring reduction of value modulo modulus (one quotient bit a cycle),
// then the loop steps in the ring of cells (about two steps per modulus bit,
// at most 136), then sign/range fix-up via t_q/addp_q and the output register.
// The result waits in the output register while out_stall is high; the
// next item may be accepted meanwhile but its result holds until then.
// Reset clears all control state; no state is kept between items.
// ----------------------------------------------------------------------------
`include "modular_inverse_macros.svh"

module modular_inverse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [mi_pkg::WIDTH-1:0]  value,
	input  logic [mi_pkg::WIDTH-1:0]  modulus,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [mi_pkg::WIDTH-1:0]  inverse,
	output logic                      status
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_RUN  = 3'd2;
	localparam logic [2:0] S_OUT  = 3'd3;

	localparam int unsigned W  = mi_pkg::WIDTH;
	localparam int unsigned DW = mi_pkg::DW;

	logic [2:0]             state_q;
	logic [W-1:0]           p_q;
	logic [W-1:0]           a_q;
	logic [W-1:0]           rem_q;
	logic [mi_pkg::DCW-1:0] cnt_q;
	logic                   inj_q;
	mi_pkg::mi_masks_t      masks_q;
	logic [DW-1:0]          t_q;
	logic                   addp_q;
	logic                   ok_q;
	logic                   out_valid_q;
	logic [W-1:0]           inverse_q;
	logic                   status_q;

	mi_pkg::mi_state_t      ring [mi_pkg::NCELLS];
	mi_pkg::mi_state_t      head;
	mi_pkg::mi_state_t      feed;
	mi_pkg::mi_state_t      init;
	mi_pkg::mi_masks_t      masks_d;
	logic [mi_pkg::NW-1:0]  nlen;
	logic [W:0]             remsh;
	logic                   capture;
	logic                   unitv;
	logic [DW-1:0]          rr;
	logic [DW-1:0]          uu;
	logic [DW-1:0]          pw;
	logic [DW-1:0]          t_d;
	logic                   addp_d;
	logic                   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign head     = ring[mi_pkg::NCELLS-1];
	assign capture  = (state_q == S_RUN) && !inj_q && head.live && head.fin;
	assign pw       = {{(DW-W){1'b0}}, p_q};

	always_comb begin
		nlen = '0;
		for (int i = 0; i < W; i++) begin
			if (modulus[i]) nlen = mi_pkg::NW'(i + 1);
		end
		masks_d.nb  = {{(DW-1){1'b0}}, 1'b1} << nlen;
		masks_d.nb1 = {{(DW-1){1'b0}}, 1'b1} << (nlen - 1'b1);
		masks_d.hi  = masks_d.nb | masks_d.nb1;
		masks_d.lo  = masks_d.nb1 - 1'b1;
	end

	always_comb begin
		init       = '0;
		init.live  = 1'b1;
		init.u     = pw;
		init.v     = {{(DW-W){1'b0}}, rem_q};
		init.s     = {{(DW-1){1'b0}}, 1'b1};
		feed       = head;
		if (capture) feed.live = 1'b0;
		if (inj_q) feed = init;
	end

	// ring of step cells, last feeds the first
	for (genvar g = 0; g < mi_pkg::NCELLS; g++) begin : g_cell
		mi_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.masks  (masks_q),
			.d      ((g == 0) ? feed : ring[(g + mi_pkg::NCELLS - 1) % mi_pkg::NCELLS]),
			.q      (ring[g])
		);
	end

	assign remsh = {rem_q, a_q[W-1]};

	// first half of the sign/range fix-up
	always_comb begin
		unitv  = mi_pkg::is_unit(head.v, head.cv);
		rr     = unitv ? head.s : head.r;
		uu     = unitv ? head.v : head.u;
		t_d    = rr;
		addp_d = 1'b0;
		if ((uu & masks_q.nb) != '0) begin
			if (rr[DW-1]) begin
				t_d = {DW{1'b0}} - rr;
			end else begin
				t_d    = pw - rr;
				addp_d = t_d[DW-1];
			end
		end else if (rr[DW-1]) begin
			addp_d = 1'b1;
		end
		if (!head.ok) begin
			t_d    = '0;
			addp_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			p_q         <= '0;
			a_q         <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			inj_q       <= 1'b0;
			masks_q     <= '0;
			t_q         <= '0;
			addp_q      <= 1'b0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
			inverse_q   <= '0;
			status_q    <= 1'b0;
		end else begin
			inj_q <= 1'b0;
			// in S_OUT the output register is reloaded instead
			if (out_valid_q && !out_stall && (state_q != S_OUT)) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						p_q     <= modulus;
						a_q     <= value;
						rem_q   <= '0;
						cnt_q   <= '0;
						masks_q <= masks_d;
						if ((modulus < W'(3)) || !modulus[0]) begin
							ok_q    <= 1'b0;
							t_q     <= '0;
							addp_q  <= 1'b0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q <= (remsh >= {1'b0, p_q}) ? W'(remsh - {1'b0, p_q}) : W'(remsh);
					a_q   <= a_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == mi_pkg::DCW'(W - 1)) begin
						inj_q   <= 1'b1;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (capture) begin
						t_q     <= t_d;
						addp_q  <= addp_d;
						ok_q    <= head.ok;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						inverse_q   <= addp_q ? W'(t_q + pw) : W'(t_q);
						status_q    <= !ok_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign inverse   = inverse_q;
	assign status    = status_q;

	`MI_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, in_stall)
	`MI_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid && out_stall, out_valid)
	`MI_ASSERT_NOW(a_fail_zero, clk, arst_n, out_valid && status, inverse == '0)

endmodule
